[design/wfa_pkg.sv]
// Shared types and constants for the worst-fit block allocator.
// No dependencies; imported by every module of the block.
package wfa_pkg;

    localparam int TABLE_DEPTH_DEF = 8;
    localparam int SIZE_BITS_DEF   = 16;

    localparam int REQ_SIZE_W  = 16;
    localparam int CAP_W       = 16;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 3;
    localparam int FREED_W     = 4;
    localparam int OUT_DATA_W  = 24;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd200;

    // register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED     = 3'd0,
        ST_APPENDED   = 3'd1,
        ST_NO_ROOM    = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_FREE_DONE  = 3'd4
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_free;
        logic over;
        logic scan_end;
        logic rd_pend;
        logic out_free;
    } dp_stat_t;

endpackage

[design/wfa_regs.sv]
// APB configuration register: the capacity limit.
// Depends on wfa_pkg.
module wfa_regs
    import wfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CAP_W-1:0]      capacity
);

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_en && paddr[2] == REG_CAPACITY)
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = APB_DATA_W'(capacity_reg);
        end
    end

    assign capacity = capacity_reg;

endmodule

[design/wfa_ctrl.sv]
// Request sequencer: accept, table scan, commit.
// Depends on wfa_pkg; drives wfa_dpath through dp_cmd_t.
module wfa_ctrl
    import wfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // refused allocations skip the table
                if (!stat.is_free && stat.over)
                begin
                    state_next = S_COMMIT;
                end
                else if (!stat.scan_end)
                begin
                    cmd.issue = 1'b1;
                end
                else if (!stat.rd_pend)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/wfa_dpath.sv]
// Allocator datapath: size memory, free marks, occupancy total, scan
// compare and the output word register. Depends on wfa_pkg.
module wfa_dpath
    import wfa_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int SIZE_BITS   = SIZE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  req_type,
    input  logic [REQ_SIZE_W-1:0] req_size,
    input  logic [CAP_W-1:0]      capacity,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [SLOT_W-1:0]     slot_index,
    output logic [CAP_W-1:0]      space_left,
    output logic [FREED_W-1:0]    freed_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SW    = SIZE_BITS;
    localparam int OW    = ((SW > CAP_W) ? SW : CAP_W) + 1;

    // size memory: one write, one registered read per cycle
    logic [SW-1:0]          entry_size_reg [TABLE_DEPTH];
    logic [SW-1:0]          rd_size_reg;

    logic [TABLE_DEPTH-1:0] entry_free_reg, entry_free_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [SW-1:0]          occ_reg, occ_next;

    logic                   type_reg, type_next;
    logic [SW-1:0]          size_reg, size_next;
    logic [CNT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [SW-1:0]          best_size_reg, best_size_next;
    logic [CNT_W-1:0]       freed_reg, freed_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [CAP_W-1:0]       space_reg, space_next;
    logic [FREED_W-1:0]     freed_out_reg, freed_out_next;

    logic [OW-1:0]          sum;
    logic                   over;
    logic                   table_full;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [SW-1:0]          occ_after;
    logic [OW-1:0]          cap_w;
    logic [OW-1:0]          occ_w;

    assign sum        = OW'(occ_reg) + OW'(size_reg);
    assign over       = (sum > OW'(capacity));
    assign table_full = (used_reg == CNT_W'(TABLE_DEPTH));

    assign stat.is_free  = (type_reg == REQ_FREE);
    assign stat.over     = over;
    assign stat.scan_end = (scan_idx_reg == used_reg);
    assign stat.rd_pend  = rd_vld_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        type_next       = type_reg;
        size_next       = size_reg;
        scan_idx_next   = scan_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_size_next  = best_size_reg;
        freed_next      = freed_reg;
        entry_free_next = entry_free_reg;
        used_next       = used_reg;
        occ_next        = occ_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        slot_next       = slot_reg;
        space_next      = space_reg;
        freed_out_next  = freed_out_reg;
        mem_we          = 1'b0;
        mem_waddr       = best_idx_reg;
        occ_after       = occ_reg;
        cap_w           = '0;
        occ_w           = '0;

        if (cmd.load)
        begin
            type_next     = req_type;
            size_next     = SW'(req_size);
            scan_idx_next = '0;
            found_next    = 1'b0;
            freed_next    = '0;
        end

        if (cmd.issue)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        // evaluate the entry read in the previous cycle
        if (rd_vld_reg)
        begin
            if (type_reg == REQ_FREE)
            begin
                if (!entry_free_reg[rd_idx_reg] && rd_size_reg == size_reg)
                begin
                    entry_free_next[rd_idx_reg] = 1'b1;
                    occ_next   = (occ_reg > size_reg) ? (occ_reg - size_reg) : '0;
                    freed_next = freed_reg + 1'b1;
                end
            end
            else if (entry_free_reg[rd_idx_reg] && rd_size_reg > size_reg &&
                     (!found_reg || rd_size_reg > best_size_reg))
            begin
                found_next     = 1'b1;
                best_idx_next  = rd_idx_reg;
                best_size_next = rd_size_reg;
            end
        end

        if (cmd.commit)
        begin
            slot_next      = '0;
            freed_out_next = '0;
            if (type_reg == REQ_FREE)
            begin
                status_next    = ST_FREE_DONE;
                freed_out_next = FREED_W'(freed_reg);
            end
            else if (over)
            begin
                status_next = ST_NO_ROOM;
            end
            else if (found_reg)
            begin
                status_next                   = ST_REUSED;
                slot_next                     = SLOT_W'(best_idx_reg);
                mem_we                        = 1'b1;
                mem_waddr                     = best_idx_reg;
                entry_free_next[best_idx_reg] = 1'b0;
                occ_after                     = SW'(sum);
            end
            else if (!table_full)
            begin
                status_next                = ST_APPENDED;
                slot_next                  = SLOT_W'(used_reg);
                mem_we                     = 1'b1;
                mem_waddr                  = IDX_W'(used_reg);
                entry_free_next[mem_waddr] = 1'b0;
                used_next                  = used_reg + 1'b1;
                occ_after                  = SW'(sum);
            end
            else
            begin
                status_next = ST_TABLE_FULL;
            end
            occ_next       = occ_after;
            cap_w          = OW'(capacity);
            occ_w          = OW'(occ_after);
            space_next     = (cap_w > occ_w) ? CAP_W'(cap_w - occ_w) : '0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_size_reg[mem_waddr] <= size_reg;
        end
        if (cmd.issue)
        begin
            rd_size_reg <= entry_size_reg[scan_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_free_reg <= '0;
            used_reg       <= '0;
            occ_reg        <= '0;
            scan_idx_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            freed_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            entry_free_reg <= entry_free_next;
            used_reg       <= used_next;
            occ_reg        <= occ_next;
            scan_idx_reg   <= scan_idx_next;
            rd_vld_reg     <= cmd.issue;
            found_reg      <= found_next;
            freed_reg      <= freed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg      <= type_next;
        size_reg      <= size_next;
        rd_idx_reg    <= scan_idx_reg[IDX_W-1:0];
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        space_reg     <= space_next;
        freed_out_reg <= freed_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_index  = slot_reg;
    assign space_left  = space_reg;
    assign freed_count = freed_out_reg;

endmodule

[design/worst_fit_block_allocator_top.sv]
// Worst-fit allocator. After a request is accepted, the n table entries in
// use are scanned (skipped for a refused allocation), then the result word
// is committed; the next request can be taken in the cycle after commit.
// The scan reads one entry per cycle through the size memory's single read
// port. rst_n is asynchronous: it empties the table, zeroes the total and
// sets capacity to 200; stored sizes are not cleared.
module worst_fit_block_allocator_top
    import wfa_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int SIZE_BITS   = SIZE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [REQ_SIZE_W-1:0] s_tdata,   // [15:0] req_size
    input  logic                  s_tuser,   // [0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [2:0] slot_index, [18:3] space_left,
                                             // [22:19] freed_count, [23] zero
    output logic [STATUS_W-1:0]   m_tuser,   // [2:0] status
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CAP_W-1:0]   capacity;
    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [SLOT_W-1:0]  slot_index;
    logic [CAP_W-1:0]   space_left;
    logic [FREED_W-1:0] freed_count;

    wfa_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    wfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wfa_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SIZE_BITS   (SIZE_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (s_tuser),
        .req_size    (s_tdata),
        .capacity    (capacity),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .status      (m_tuser),
        .slot_index  (slot_index),
        .space_left  (space_left),
        .freed_count (freed_count)
    );

    assign m_tdata = {1'b0, freed_count, space_left, slot_index};

endmodule
